// ----- rtl/cubic_power_estimator_defines.svh -----
// ----------------------------------------------------------------------------
// cubic_power_estimator_defines
// assertion macros shared by the power estimator rtl
// ----------------------------------------------------------------------------
`ifndef CUBIC_POWER_ESTIMATOR_DEFINES_SVH
`define CUBIC_POWER_ESTIMATOR_DEFINES_SVH

// same-cycle implication, checked on clk, off during rst
`define CPE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define CPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cpe_pkg.sv -----
// ----------------------------------------------------------------------------
// cpe_pkg
// types, coefficient table and register codes of the cubic power estimator
// ----------------------------------------------------------------------------
`default_nettype none

package cpe_pkg;

  localparam int TERM_COUNT = 10;
  localparam int TERM_IDX_W = 4;
  localparam int NSTAGE     = 8;
  localparam int POWER_W    = 12;
  localparam int M_TDATA_W  = 16;
  localparam int CADENCE_W  = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 12;
  localparam int MAG_W      = 36;

  localparam logic [CADENCE_W-1:0] FLOOR_RESET   = 8'd20;
  localparam logic [CADENCE_W-1:0] CEILING_RESET = 8'd150;
  localparam logic [POWER_W-1:0]   CAP_RESET     = 12'd999;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FLOOR   = 2'd0,
    REG_CEILING = 2'd1,
    REG_CAP     = 2'd2
  } cfg_reg_t;

  // which variable feeds each multiplier of a term chain
  typedef enum logic [1:0] {
    VSEL_ONE = 2'd0,
    VSEL_X   = 2'd1,
    VSEL_Y   = 2'd2
  } vsel_t;

  // term order: 1, x, y, x^2, xy, y^2, x^3, x^2y, xy^2, y^3
  localparam logic [MAG_W-1:0] COEF_MAG_Q32 [TERM_COUNT] = '{
    36'd14156212208, 36'd3519296202, 36'd1230078634, 36'd104797202, 36'd51367809,
    36'd78597902, 36'd436369, 36'd2329590, 36'd376497, 36'd366318
  };

  localparam logic COEF_NEG [TERM_COUNT] = '{
    1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1
  };

  localparam vsel_t SEL_A [TERM_COUNT] = '{
    VSEL_ONE, VSEL_X, VSEL_Y, VSEL_X, VSEL_X, VSEL_Y, VSEL_X, VSEL_X, VSEL_X, VSEL_Y
  };
  localparam vsel_t SEL_B [TERM_COUNT] = '{
    VSEL_ONE, VSEL_ONE, VSEL_ONE, VSEL_X, VSEL_Y, VSEL_Y, VSEL_X, VSEL_X, VSEL_Y, VSEL_Y
  };
  localparam vsel_t SEL_C [TERM_COUNT] = '{
    VSEL_ONE, VSEL_ONE, VSEL_ONE, VSEL_ONE, VSEL_ONE, VSEL_ONE, VSEL_X, VSEL_Y, VSEL_Y,
    VSEL_Y
  };

  // q32 magnitude rounded half up to frac fractional bits
  function automatic logic [MAG_W-1:0] coef_mag(input logic [TERM_IDX_W-1:0] idx,
                                                input int unsigned frac);
    logic [MAG_W-1:0] m;
    int unsigned      sh;
    m  = COEF_MAG_Q32[idx];
    sh = 32 - frac;
    if (sh == 0) begin
      return m;
    end
    return (m + (MAG_W'(1) << (sh - 1))) >> sh;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cubic_power_estimator.sv -----
// ----------------------------------------------------------------------------
// cubic_power_estimator
// pipelined ten-term bivariate cubic power estimate from resistance and cadence
// ----------------------------------------------------------------------------
//  channel   dir  handshake            contents
//  s_*       in   s_tvalid/s_tready    resistance_level, cadence_rpm
//  m_*       out  m_tvalid/m_tready    power_watts
//  cfg_*     in   cfg_we               cadence_floor, cadence_ceiling, power_cap
//
//  one transaction per cycle sustained while m_tready is high
//  depth is set by the three chained multipliers per term and the adder tree
//  each stage holds unless the one after it is empty or moving, so bubbles close
//  a stalled output keeps its data while earlier stages keep filling
//  rst clears the valid bits and loads the register reset values
// ----------------------------------------------------------------------------
`default_nettype none

`include "cubic_power_estimator_defines.svh"

module cubic_power_estimator #(
  parameter int INPUT_BITS     = 8,
  parameter int COEF_FRAC_BITS = 24,
  localparam int S_TDATA_W     = ((2 * INPUT_BITS + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // resistance_level, cadence_rpm
  input  wire logic [S_TDATA_W-1:0]            s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // power_watts
  output logic [cpe_pkg::M_TDATA_W-1:0]        m_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [cpe_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [cpe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import cpe_pkg::*;

  localparam int IB    = INPUT_BITS;
  localparam int CW    = COEF_FRAC_BITS + 3;
  localparam int P1_W  = CW + IB;
  localparam int P2_W  = CW + 2 * IB;
  localparam int TW    = CW + 3 * IB;
  localparam int QW    = TW + 1;
  localparam int R0_W  = TW + 3;
  localparam int R1_W  = TW + 2;
  localparam int ACC_W = TW + 4;
  localparam int IP_W  = ACC_W - COEF_FRAC_BITS;

  // configuration registers
  logic [CADENCE_W-1:0] cadence_floor;
  logic [CADENCE_W-1:0] cadence_ceiling;
  logic [POWER_W-1:0]   power_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      cadence_floor   <= FLOOR_RESET;
      cadence_ceiling <= CEILING_RESET;
      power_cap       <= CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FLOOR:   cadence_floor   <= cfg_wdata[CADENCE_W-1:0];
        REG_CEILING: cadence_ceiling <= cfg_wdata[CADENCE_W-1:0];
        REG_CAP:     power_cap       <= cfg_wdata[POWER_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NSTAGE-1:0] valid;
  logic [NSTAGE-1:0] en;

  assign en[NSTAGE-1] = !valid[NSTAGE-1] || m_tready;
  for (genvar k = 0; k < NSTAGE - 1; k++) begin : g_en
    assign en[k] = !valid[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= (en & {valid[NSTAGE-2:0], s_tvalid}) | (~en & valid);
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = valid[NSTAGE-1];

  // stage 0: floor test and ceiling clamp
  logic [IB-1:0] res_in;
  logic [IB-1:0] cad_in;
  logic [IB-1:0] x0, y0;
  logic          zero0;

  assign res_in = s_tdata[IB-1:0];
  assign cad_in = s_tdata[2*IB-1:IB];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0    <= res_in;
      y0    <= (cad_in > IB'(cadence_ceiling)) ? IB'(cadence_ceiling) : cad_in;
      zero0 <= cad_in < IB'(cadence_floor);
    end
  end

  // stages 1..3: coefficient times three variables, one multiplier per stage
  logic [IB-1:0]           x1, y1, x2, y2;
  logic                    zero1, zero2, zero3;
  logic signed [P1_W-1:0]  p1 [TERM_COUNT];
  logic signed [P2_W-1:0]  p2 [TERM_COUNT];
  logic signed [TW-1:0]    p3 [TERM_COUNT];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1    <= x0;
      y1    <= y0;
      zero1 <= zero0;
    end
    if (en[2]) begin
      x2    <= x1;
      y2    <= y1;
      zero2 <= zero1;
    end
    if (en[3]) begin
      zero3 <= zero2;
    end
  end

  for (genvar i = 0; i < TERM_COUNT; i++) begin : g_term
    localparam logic [MAG_W-1:0] MAG = coef_mag(TERM_IDX_W'(i), COEF_FRAC_BITS);
    localparam logic signed [CW-1:0] COEF =
      COEF_NEG[i] ? $signed(-CW'(MAG)) : $signed(CW'(MAG));

    logic [IB-1:0] op_a, op_b, op_c;

    assign op_a = (SEL_A[i] == VSEL_X) ? x0 : (SEL_A[i] == VSEL_Y) ? y0 : IB'(1);
    assign op_b = (SEL_B[i] == VSEL_X) ? x1 : (SEL_B[i] == VSEL_Y) ? y1 : IB'(1);
    assign op_c = (SEL_C[i] == VSEL_X) ? x2 : (SEL_C[i] == VSEL_Y) ? y2 : IB'(1);

    always_ff @(posedge clk) begin
      if (en[1]) begin
        p1[i] <= P1_W'(COEF) * P1_W'($signed({1'b0, op_a}));
      end
      if (en[2]) begin
        p2[i] <= P2_W'(p1[i]) * P2_W'($signed({1'b0, op_b}));
      end
      if (en[3]) begin
        p3[i] <= TW'(p2[i]) * TW'($signed({1'b0, op_c}));
      end
    end
  end

  // stages 4..6: adder tree
  logic signed [QW-1:0]    q [TERM_COUNT/2];
  logic signed [R0_W-1:0]  r0;
  logic signed [R1_W-1:0]  r1;
  logic signed [ACC_W-1:0] acc;
  logic                    zero4, zero5, zero6;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int j = 0; j < TERM_COUNT / 2; j++) begin
        q[j] <= QW'(p3[2*j]) + QW'(p3[2*j+1]);
      end
      zero4 <= zero3;
    end
    if (en[5]) begin
      r0    <= R0_W'(q[0]) + R0_W'(q[1]) + R0_W'(q[2]);
      r1    <= R1_W'(q[3]) + R1_W'(q[4]);
      zero5 <= zero4;
    end
    if (en[6]) begin
      acc   <= ACC_W'(r0) + ACC_W'(r1);
      zero6 <= zero5;
    end
  end

  // stage 7: truncate to integer watts, floor at zero, limit to cap
  logic [IP_W-1:0]    int_part;
  logic               non_pos;
  logic [POWER_W-1:0] power_next;
  logic [POWER_W-1:0] power_watts;

  assign int_part = acc[ACC_W-1:COEF_FRAC_BITS];
  assign non_pos  = acc[ACC_W-1] || (acc == '0);

  always_comb begin
    if (zero6 || non_pos) begin
      power_next = '0;
    end else if (int_part > IP_W'(power_cap)) begin
      power_next = power_cap;
    end else begin
      power_next = int_part[POWER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      power_watts <= power_next;
    end
  end

  assign m_tdata = M_TDATA_W'(power_watts);

  // a blocked input means every stage holds a transaction
  `CPE_ASSERT_IMPL(a_full_when_blocked, !s_tready, (&valid) && !m_tready,
                   "input blocked with a bubble in the pipeline")
  // a low-cadence transaction leaving the tree reaches the output as zero
  `CPE_ASSERT_NEXT(a_low_cadence_zero, valid[6] && en[6] && zero6,
                   m_tvalid && (power_watts == '0), "low cadence did not give zero power")

endmodule

`default_nettype wire
